[src/fesw_pkg.sv]
`timescale 1ns / 1ps

package fesw_pkg;

  localparam int FIELD_WIDTH  = 320;
  localparam int FIELD_HEIGHT = 240;

  localparam int COL_W = $clog2(FIELD_WIDTH);
  localparam int ROW_W = $clog2(FIELD_HEIGHT + 2);

  // visible rows 1..FIELD_HEIGHT-1, stored in sweep order
  localparam int FS_DEPTH = (FIELD_HEIGHT - 1) * FIELD_WIDTH;
  localparam int FS_AW    = $clog2(FS_DEPTH);

  localparam int HEAT_W = 7;
  localparam int SUM_W  = 10;   // 5 * 127 fits
  localparam int PX_W   = 9;
  localparam int PY_W   = 8;

  // x / 5 == (x * 205) >> 10 for x <= 5 * 127
  localparam int RECIP_W  = 8;
  localparam int RECIP_SH = 10;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(205);
  localparam logic [SUM_W-1:0]   SUM_MAX = SUM_W'(5 * 127);

  localparam logic [COL_W-1:0] COL_LAST    = COL_W'(FIELD_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_SRC_BOT = ROW_W'(FIELD_HEIGHT + 1);
  localparam logic [ROW_W-1:0] ROW_VIS_END = ROW_W'(FIELD_HEIGHT);
  localparam logic [ROW_W-1:0] ROW_TOP     = ROW_W'(1);
  localparam logic [FS_AW-1:0] FS_LAST     = FS_AW'(FS_DEPTH - 1);

endpackage

[src/fesw_if.sv]
`timescale 1ns / 1ps

interface fesw_in_if;
  import fesw_pkg::*;

  logic              valid;
  logic              ready;
  logic [HEAT_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

interface fesw_out_if;
  import fesw_pkg::*;

  logic              valid;
  logic              ready;
  logic [PX_W-1:0]   pos_x;
  logic [PY_W-1:0]   pos_y;
  logic [HEAT_W-1:0] heat;
  logic              frame_done;

  modport source (output valid, output pos_x, output pos_y, output heat, output frame_done,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heat, input frame_done,
                  output ready);
endinterface

[src/fire_effect_heat_sweep.sv]
`timescale 1ns / 1ps

// Fire effect heat-field updater.
// in_ch: one beat per field position, in frame order. The first two rows of a
// frame are the source rows: the seed is stored and no beat comes out. The
// visible rows then follow bottom to top, columns left to right; each such
// beat yields one out_ch beat with the cell position, its new heat value and
// frame_done on the top row's last column.
// Three register stages: memory read, five-cell sum, divide by 5; the last of
// them is the output register that out_ch reads.
// Throughput is one beat per clock while out_ch does not stall; per cycle
// the frame store takes one read and one write, the row-below buffer two
// reads and one write, the other line buffer one read and one write.
// Reset empties the pipeline and restarts at the bottom source row, column 0.
// The frame store's read is left out of the sum until the first full sweep
// has written it, so no clearing pass is run.
// When out_ch stalls, the output register holds; bubbles ahead of it fill up
// and then in_ch.ready drops. Nothing is lost or repeated.
module fire_effect_heat_sweep (
  input  logic        clk,
  input  logic        rst_n,
  fesw_in_if.sink     in_ch,
  fesw_out_if.source  out_ch
);
  import fesw_pkg::*;

  // position counters
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [FS_AW-1:0] fs_addr_r;
  logic             warm_r;

  // memories
  logic [HEAT_W-1:0] fs_mem [FS_DEPTH];
  logic [HEAT_W-1:0] lb1_mem [FIELD_WIDTH];  // row below, this frame
  logic [HEAT_W-1:0] lb2_mem [FIELD_WIDTH];  // two rows below, this frame

  // stage 1
  logic              s1_v_r, s1_sweep_r, s1_first_r, s1_lastc_r, s1_done_r, s1_warm_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [FS_AW-1:0]  s1_fs_addr_r;
  logic [HEAT_W-1:0] s1_seed_r;
  logic [HEAT_W-1:0] fs_rd_r, p0_rd_r, p1_rd_r, q_rd_r;
  logic [HEAT_W-1:0] p_left_r;

  // stage 2
  logic              s2_v_r, s2_sweep_r, s2_done_r;
  logic [COL_W-1:0]  s2_col_r;
  logic [ROW_W-1:0]  s2_row_r;
  logic [FS_AW-1:0]  s2_fs_addr_r;
  logic [HEAT_W-1:0] s2_seed_r, s2_p0_r;
  logic [SUM_W-1:0]  s2_sum_r;

  // stage 3 / output register
  logic              s3_v_r, s3_done_r;
  logic [PX_W-1:0]   s3_x_r;
  logic [PY_W-1:0]   s3_y_r;
  logic [HEAT_W-1:0] s3_heat_r;

  logic              go_1, go_2, go_3, acc;
  logic              in_sweep, in_lastc, in_done;
  logic [COL_W-1:0]  col_nxt, p1_addr;
  logic [ROW_W-1:0]  row_nxt;
  logic [FS_AW-1:0]  fs_addr_nxt;
  logic              warm_nxt;
  logic [SUM_W-1:0]  sum1;
  logic [PROD_W-1:0] prod2;
  logic [HEAT_W-1:0] heat2, val2;
  logic              wr2;

  // handshake / advance
  assign go_3 = !s3_v_r || out_ch.ready;
  assign go_2 = !s2_v_r || go_3;
  assign go_1 = !s1_v_r || go_2;
  assign in_ch.ready = go_1;
  assign acc = in_ch.valid && go_1;

  assign in_sweep = row_r < ROW_VIS_END;
  assign in_lastc = col_r == COL_LAST;
  assign in_done  = in_lastc && (row_r == ROW_TOP);
  assign p1_addr  = in_lastc ? col_r : col_r + COL_W'(1);

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    fs_addr_nxt = fs_addr_r;
    warm_nxt    = warm_r;
    if (acc) begin
      if (in_lastc) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_TOP) ? ROW_SRC_BOT : row_r - ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (in_done) begin
        fs_addr_nxt = '0;
        warm_nxt    = 1'b1;
      end else if (in_sweep) begin
        fs_addr_nxt = fs_addr_r + FS_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= ROW_SRC_BOT;
      fs_addr_r <= '0;
      warm_r    <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      fs_addr_r <= fs_addr_nxt;
      warm_r    <= warm_nxt;
    end
  end

  // stage 2 writes back: line buffers shift one row, visible cells go to the store
  assign prod2 = PROD_W'(s2_sum_r) * PROD_W'(RECIP);
  assign heat2 = prod2[RECIP_SH +: HEAT_W];
  assign val2  = s2_sweep_r ? heat2 : s2_seed_r;
  assign wr2   = s2_v_r && go_3;

  always_ff @(posedge clk) begin
    if (wr2 && s2_sweep_r) begin
      fs_mem[s2_fs_addr_r] <= heat2;
    end
    if (acc) begin
      fs_rd_r <= fs_mem[fs_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr2) begin
      lb1_mem[s2_col_r] <= val2;
    end
    if (acc) begin
      p0_rd_r <= lb1_mem[col_r];
      p1_rd_r <= lb1_mem[p1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr2) begin
      lb2_mem[s2_col_r] <= s2_p0_r;
    end
    if (acc) begin
      q_rd_r <= lb2_mem[col_r];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (go_1) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_sweep_r   <= in_sweep;
      s1_first_r   <= col_r == '0;
      s1_lastc_r   <= in_lastc;
      s1_done_r    <= in_done;
      s1_warm_r    <= warm_r;
      s1_col_r     <= col_r;
      s1_row_r     <= row_r;
      s1_fs_addr_r <= fs_addr_r;
      s1_seed_r    <= in_ch.seed;
    end
    // previous column's center tap becomes this column's left tap
    if (s1_v_r && go_2) begin
      p_left_r <= p0_rd_r;
    end
  end

  always_comb begin
    sum1 = SUM_W'(p0_rd_r) + SUM_W'(q_rd_r);
    if (s1_warm_r) begin
      sum1 = sum1 + SUM_W'(fs_rd_r);
    end
    if (!s1_first_r) begin
      sum1 = sum1 + SUM_W'(p_left_r);
    end
    if (!s1_lastc_r) begin
      sum1 = sum1 + SUM_W'(p1_rd_r);
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (go_2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go_2) begin
      s2_sweep_r   <= s1_sweep_r;
      s2_done_r    <= s1_done_r;
      s2_col_r     <= s1_col_r;
      s2_row_r     <= s1_row_r;
      s2_fs_addr_r <= s1_fs_addr_r;
      s2_seed_r    <= s1_seed_r;
      s2_p0_r      <= p0_rd_r;
      s2_sum_r     <= sum1;
    end
  end

  // stage 3: output register, source-row beats drop out here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (go_3) begin
      s3_v_r <= s2_v_r && s2_sweep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go_3) begin
      s3_x_r    <= PX_W'(s2_col_r);
      s3_y_r    <= PY_W'(s2_row_r);
      s3_heat_r <= heat2;
      s3_done_r <= s2_done_r;
    end
  end

  assign out_ch.valid      = s3_v_r;
  assign out_ch.pos_x      = s3_x_r;
  assign out_ch.pos_y      = s3_y_r;
  assign out_ch.heat       = s3_heat_r;
  assign out_ch.frame_done = s3_done_r;

  // source-row beats carry a don't-care sum
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_sweep_r |-> s2_sum_r <= SUM_MAX)
    else $error("five-cell sum out of range");

  a_store_addr: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_sweep_r |-> s2_fs_addr_r <= FS_LAST)
    else $error("frame store address past end");

  a_wrap_addr: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_done |-> fs_addr_r == FS_LAST)
    else $error("sweep count out of step with frame wrap");

  a_source_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_sweep |=> s1_v_r && !s1_sweep_r)
    else $error("source row beat marked as sweep");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fesw_pkg::*;

  typedef struct packed {
    logic [PX_W-1:0]   pos_x;
    logic [PY_W-1:0]   pos_y;
    logic [HEAT_W-1:0] heat;
    logic              frame_done;
  } cell_beat_t;

  typedef struct {
    logic [HEAT_W-1:0] seed;
    bit                typed;
    bit                has_beat;
    cell_beat_t        beat;
  } opening_row_t;

  typedef enum {ROW_HOT, ROW_COLD, ROW_STRIPED, ROW_NOISE} row_style_t;

  localparam int ROWS_TOTAL      = FIELD_HEIGHT + 2;
  localparam int AVG_TAPS        = 5;
  localparam int OPENING_ITEMS   = 20;
  localparam int RANDOM_ITEMS    = 1600 - OPENING_ITEMS;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT     = 1000;
  localparam int DRAIN_AT        = 700;
  localparam int QUIET_FROM      = 1100;
  localparam int QUIET_TO        = 1500;
  localparam int DRAIN_CYCLES    = 20;
  localparam int REPORT_LIMIT    = 10;
  localparam int CYCLE_LIMIT     = 6 * (OPENING_ITEMS + RANDOM_ITEMS) + 4 * HOLD_OFF_CYCLES
                                   + 10000;

  logic clk;
  logic rst_n;

  fesw_in_if  seed_ch ();
  fesw_out_if cell_ch ();

  fire_effect_heat_sweep dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (seed_ch),
    .out_ch (cell_ch)
  );

  // Mirror of the heat field and sweep position
  logic [HEAT_W-1:0] heat_map [ROWS_TOTAL * FIELD_WIDTH];
  int unsigned       sweep_col;
  int unsigned       sweep_row;

  cell_beat_t heat_due [$];
  int         mismatch_count;
  int         cycle_count;
  bit         quiet;
  bit         hold_off_due;
  row_style_t row_style;

  // Opening beats all land in the bottom source row, so none of them yields a beat
  opening_row_t opening_rows [OPENING_ITEMS] = '{
    '{7'h00, 1'b1, 1'b0, '0}, '{7'h7f, 1'b1, 1'b0, '0}, '{7'h55, 1'b1, 1'b0, '0},
    '{7'h2a, 1'b1, 1'b0, '0}, '{7'h01, 1'b1, 1'b0, '0}, '{7'h40, 1'b1, 1'b0, '0},
    '{7'h7e, 1'b1, 1'b0, '0}, '{7'h3f, 1'b1, 1'b0, '0}, '{7'h7f, 1'b1, 1'b0, '0},
    '{7'h7f, 1'b1, 1'b0, '0}, '{7'h00, 1'b1, 1'b0, '0}, '{7'h00, 1'b1, 1'b0, '0},
    '{7'h7f, 1'b1, 1'b0, '0}, '{7'h00, 1'b1, 1'b0, '0}, '{7'h7f, 1'b1, 1'b0, '0},
    '{7'h13, 1'b0, 1'b0, '0}, '{7'h6c, 1'b0, 1'b0, '0}, '{7'h21, 1'b0, 1'b0, '0},
    '{7'h5e, 1'b0, 1'b0, '0}, '{7'h7f, 1'b0, 1'b0, '0}
  };

  function automatic int unsigned cell_index(input int unsigned row, input int unsigned col);
    return row * FIELD_WIDTH + col;
  endfunction

  // Stores a seed in the source rows, otherwise averages the cell with its
  // neighbors below in place and yields the updated cell.
  function automatic bit sweep_cell(input logic [HEAT_W-1:0] seed, output cell_beat_t beat);
    int unsigned       total;
    logic [HEAT_W-1:0] fresh;
    bit                produced;
    beat = '0;
    produced = 1'b0;
    if (sweep_row >= FIELD_HEIGHT) begin
      heat_map[cell_index(sweep_row, sweep_col)] = seed;
    end else begin
      total = heat_map[cell_index(sweep_row, sweep_col)]
            + heat_map[cell_index(sweep_row + 1, sweep_col)]
            + heat_map[cell_index(sweep_row + 2, sweep_col)];
      // neighbors past either edge read as zero
      if (sweep_col > 0)
        total += heat_map[cell_index(sweep_row + 1, sweep_col - 1)];
      if (sweep_col + 1 < FIELD_WIDTH)
        total += heat_map[cell_index(sweep_row + 1, sweep_col + 1)];
      fresh = HEAT_W'(total / AVG_TAPS);
      heat_map[cell_index(sweep_row, sweep_col)] = fresh;
      beat.pos_x      = PX_W'(sweep_col);
      beat.pos_y      = PY_W'(sweep_row);
      beat.heat       = fresh;
      beat.frame_done = (sweep_row == 1 && sweep_col + 1 == FIELD_WIDTH);
      produced = 1'b1;
    end
    sweep_col++;
    if (sweep_col >= FIELD_WIDTH) begin
      sweep_col = 0;
      if (sweep_row <= 1)
        sweep_row = FIELD_HEIGHT + 1;
      else
        sweep_row--;
    end
    return produced;
  endfunction

  task automatic flag_mismatch(input string what, input cell_beat_t want, input cell_beat_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display({"%0t %s: expected x=%0d y=%0d heat=%0d done=%0b, ",
                "got x=%0d y=%0d heat=%0d done=%0b"},
               $time, what, want.pos_x, want.pos_y, want.heat, want.frame_done,
               got.pos_x, got.pos_y, got.heat, got.frame_done);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_seed(input logic [HEAT_W-1:0] seed, output bit produced,
                            output cell_beat_t beat);
    seed_ch.valid <= 1'b1;
    seed_ch.seed  <= seed;
    do @(posedge clk); while (!seed_ch.ready);
    produced = sweep_cell(seed, beat);
    if (produced)
      heat_due.push_back(beat);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    while (!quiet && $urandom_range(99) < 12) begin
      seed_ch.valid <= 1'b0;
      seed_ch.seed  <= HEAT_W'($urandom);
      @(negedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk) begin
    cell_beat_t got;
    cell_beat_t want;
    if (rst_n && cell_ch.valid && cell_ch.ready) begin
      got.pos_x      = cell_ch.pos_x;
      got.pos_y      = cell_ch.pos_y;
      got.heat       = cell_ch.heat;
      got.frame_done = cell_ch.frame_done;
      if (heat_due.size() == 0) begin
        flag_mismatch("unexpected beat", '0, got);
      end else begin
        want = heat_due.pop_front();
        if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.heat !== want.heat || got.frame_done !== want.frame_done)
          flag_mismatch("cell mismatch", want, got);
      end
    end
  end

  // Receiver: random stalls, a quiet stretch, and a long hold-off on request
  initial begin
    cell_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        cell_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        cell_ch.ready <= quiet || $urandom_range(99) >= 12;
        @(negedge clk);
      end
    end
  end

  initial begin
    bit                produced;
    cell_beat_t        beat;
    logic [HEAT_W-1:0] seed;
    rst_n         = 1'b0;
    seed_ch.valid = 1'b0;
    seed_ch.seed  = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    quiet          = 1'b0;
    hold_off_due   = 1'b0;
    row_style      = ROW_NOISE;
    foreach (heat_map[i]) heat_map[i] = '0;
    sweep_col = 0;
    sweep_row = FIELD_HEIGHT + 1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) begin
      offer_seed(opening_rows[i].seed, produced, beat);
      if (opening_rows[i].typed && (produced != opening_rows[i].has_beat ||
          (produced && beat !== opening_rows[i].beat)))
        flag_mismatch("table entry", opening_rows[i].beat, beat);
      idle_gap();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_OFF_AT)
        hold_off_due = 1'b1;
      // let the block drain completely once during the sweep
      if (n == DRAIN_AT) begin
        seed_ch.valid <= 1'b0;
        do @(negedge clk); while (heat_due.size() != 0);
      end
      quiet = (n >= QUIET_FROM && n < QUIET_TO);
      if (sweep_col == 0 && sweep_row >= FIELD_HEIGHT) begin
        case ($urandom_range(9))
          0:       row_style = ROW_HOT;
          1:       row_style = ROW_COLD;
          2:       row_style = ROW_STRIPED;
          default: row_style = ROW_NOISE;
        endcase
      end
      case (row_style)
        ROW_HOT:     seed = '1;
        ROW_COLD:    seed = '0;
        ROW_STRIPED: seed = sweep_col[0] ? '1 : '0;
        default:     seed = HEAT_W'($urandom);
      endcase
      idle_gap();
      offer_seed(seed, produced, beat);
    end

    seed_ch.valid <= 1'b0;
    quiet = 1'b0;
    while (heat_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

[fire_effect_heat_sweep.f]
src/fesw_pkg.sv
src/fesw_if.sv
src/fire_effect_heat_sweep.sv
dv/testbench.sv
